// File: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/emmd_pkg.sv
package emmd_pkg;

    // Fixed decode windows.
    localparam logic [31:0] RAM_BASE     = 32'h0800_0000;
    localparam logic [31:0] RAM_SIZE     = 32'h0200_0000;
    localparam logic [31:0] VRAM_BASE    = 32'h0400_0000;
    localparam logic [31:0] VRAM_SIZE    = 32'h0020_0000;
    localparam logic [31:0] SCRATCH_BASE = 32'h0001_0000;
    localparam logic [31:0] SCRATCH_SIZE = 32'h0000_4000;

    localparam logic [31:0] ADDRESS_MASK_RESET = 32'h1FFF_FFFF;
    localparam logic [31:0] COUNT_MAX          = 32'hFFFF_FFFF;

    // Access codes.
    localparam logic [1:0] ACT_SINGLE_READ  = 2'd0;
    localparam logic [1:0] ACT_SINGLE_WRITE = 2'd1;
    localparam logic [1:0] ACT_BLOCK_READ   = 2'd2;
    localparam logic [1:0] ACT_BLOCK_WRITE  = 2'd3;

    // Region codes.
    localparam logic [2:0] REGION_NONE    = 3'd0;
    localparam logic [2:0] REGION_MODULE  = 3'd1;
    localparam logic [2:0] REGION_RAM     = 3'd2;
    localparam logic [2:0] REGION_VRAM    = 3'd3;
    localparam logic [2:0] REGION_SCRATCH = 3'd4;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_ADDRESS_MASK = 2'd0;
    localparam logic [1:0] REG_MODULE_BASE  = 2'd1;
    localparam logic [1:0] REG_MODULE_SIZE  = 2'd2;
    localparam logic [1:0] REG_WATCH_ADDR   = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] address;
        logic [16:0] access_length;
    } emmd_req_t;

    typedef struct packed {
        logic        mapped;
        logic [2:0]  region;
        logic [31:0] region_offset;
        logic        store_enable;
        logic        watch_hit;
        logic [31:0] bad_access_total;
        logic [31:0] watch_hit_total;
    } emmd_rsp_t;

    typedef struct packed {
        logic [31:0] address_mask;
        logic [31:0] module_window_base;
        logic [31:0] module_window_size;
        logic [31:0] watched_address;
    } emmd_cfg_t;

    typedef struct packed {
        logic        mapped;
        logic [2:0]  region;
        logic [31:0] region_offset;
        logic        store_enable;
        logic        watch_hit;
        logic        count_bad;
    } emmd_dec_t;

endpackage

// File: rtl/emmd_decode.sv
module emmd_decode (
    input  emmd_pkg::emmd_req_t req,
    input  emmd_pkg::emmd_cfg_t cfg,
    output emmd_pkg::emmd_dec_t dec
);

    logic [31:0] addr;
    logic [32:0] addr_x;
    logic [32:0] end_x;
    logic [32:0] raw_end_x;

    logic [32:0] mod_limit;
    logic        mod_hit, mod_fit;
    logic        ram_hit, ram_fit;
    logic        vram_hit, vram_fit;
    logic        scr_hit, scr_fit;

    logic        is_single;
    logic        is_write;
    logic        fit;

    assign addr      = req.address & cfg.address_mask;
    assign addr_x    = {1'b0, addr};
    assign end_x     = addr_x + {16'b0, req.access_length};
    assign raw_end_x = {1'b0, req.address} + {16'b0, req.access_length};
    assign mod_limit = {1'b0, cfg.module_window_base} + {1'b0, cfg.module_window_size};

    // Each window hits when the masked address lies in [base, base + size);
    // it fits when the end of the access does not pass base + size.
    assign mod_hit  = (cfg.module_window_size != 32'b0) &&
                      (addr >= cfg.module_window_base) && (addr_x < mod_limit);
    assign mod_fit  = end_x <= mod_limit;

    assign ram_hit  = (addr >= emmd_pkg::RAM_BASE) &&
                      (addr_x < ({1'b0, emmd_pkg::RAM_BASE} + {1'b0, emmd_pkg::RAM_SIZE}));
    assign ram_fit  = end_x <= ({1'b0, emmd_pkg::RAM_BASE} + {1'b0, emmd_pkg::RAM_SIZE});

    assign vram_hit = (addr >= emmd_pkg::VRAM_BASE) &&
                      (addr_x < ({1'b0, emmd_pkg::VRAM_BASE} + {1'b0, emmd_pkg::VRAM_SIZE}));
    assign vram_fit = end_x <= ({1'b0, emmd_pkg::VRAM_BASE} + {1'b0, emmd_pkg::VRAM_SIZE});

    assign scr_hit  = (addr >= emmd_pkg::SCRATCH_BASE) &&
                      (addr_x < ({1'b0, emmd_pkg::SCRATCH_BASE} +
                                 {1'b0, emmd_pkg::SCRATCH_SIZE}));
    assign scr_fit  = end_x <= ({1'b0, emmd_pkg::SCRATCH_BASE} +
                                {1'b0, emmd_pkg::SCRATCH_SIZE});

    assign is_single = (req.action == emmd_pkg::ACT_SINGLE_READ) ||
                       (req.action == emmd_pkg::ACT_SINGLE_WRITE);
    assign is_write  = (req.action == emmd_pkg::ACT_SINGLE_WRITE) ||
                       (req.action == emmd_pkg::ACT_BLOCK_WRITE);

    always_comb begin
        fit               = 1'b0;
        dec.region        = emmd_pkg::REGION_NONE;
        dec.region_offset = 32'b0;
        // The first window that matches decides; a straddle there is unmapped.
        if (mod_hit) begin
            fit               = mod_fit;
            dec.region        = emmd_pkg::REGION_MODULE;
            dec.region_offset = addr - cfg.module_window_base;
        end else if (ram_hit) begin
            fit               = ram_fit;
            dec.region        = emmd_pkg::REGION_RAM;
            dec.region_offset = addr - emmd_pkg::RAM_BASE;
        end else if (vram_hit) begin
            fit               = vram_fit;
            dec.region        = emmd_pkg::REGION_VRAM;
            dec.region_offset = addr - emmd_pkg::VRAM_BASE;
        end else if (scr_hit) begin
            fit               = scr_fit;
            dec.region        = emmd_pkg::REGION_SCRATCH;
            dec.region_offset = addr - emmd_pkg::SCRATCH_BASE;
        end
        if (!fit) begin
            dec.region        = emmd_pkg::REGION_NONE;
            dec.region_offset = 32'b0;
        end
        dec.mapped       = fit;
        dec.store_enable = fit && is_write;
        dec.count_bad    = !fit && is_single;
        // The watch compares against the raw address, not the masked one.
        dec.watch_hit    = fit && is_single && is_write &&
                           (cfg.watched_address != 32'b0) &&
                           (req.address <= cfg.watched_address) &&
                           ({1'b0, cfg.watched_address} < raw_end_x);
    end

endmodule

// File: rtl/emulated_memory_map_decoder_core.sv
// Path: an accepted request is held in the input register, decoded by a single pass of
// compares, and registered into the result register once that one is empty or draining.
// Throughput: one request per cycle while the result channel is not stalled by m_ready.
// Reset: aresetn is synchronous and active low; it empties both stages, zeroes both counters,
// and returns the configuration registers to mask 0x1FFFFFFF, module window off, watch off.
module emulated_memory_map_decoder_core (
    input  logic                aclk,
    input  logic                aresetn,

    // Request channel.
    input  logic                s_valid,
    output logic                s_ready,
    input  emmd_pkg::emmd_req_t s_data,

    // Result channel.
    output logic                m_valid,
    input  logic                m_ready,
    output emmd_pkg::emmd_rsp_t m_data,

    // Configuration port.
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // Configuration registers.
    emmd_pkg::emmd_cfg_t cfg_reg;

    // Stage one holds the accepted request; stage two holds the finished result.
    logic                in_valid_reg;
    emmd_pkg::emmd_req_t in_req_reg;
    logic                out_valid_reg;
    emmd_pkg::emmd_rsp_t out_rsp_reg;

    // Running counters and their next values.
    logic [31:0]         bad_cnt_reg;
    logic [31:0]         bad_cnt_next;
    logic [31:0]         watch_cnt_reg;
    logic [31:0]         watch_cnt_next;

    emmd_pkg::emmd_dec_t dec;
    logic                advance;
    logic                cfg_wr;
    logic [1:0]          cfg_idx;

    // The decode sits between the two registers.
    emmd_decode u_decode (
        .req (in_req_reg),
        .cfg (cfg_reg),
        .dec (dec)
    );

    // A request moves into the result register whenever that register is
    // empty or is being drained this cycle, so the input stage accepts a new
    // request in the same cycle that its current one moves on.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_rsp_reg;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    // Counters saturate at all ones. A write to the watch register clears the hit counter;
    // the user must make it only while no request is in flight; the block leaves that to them.
    always_comb begin
        bad_cnt_next   = bad_cnt_reg;
        watch_cnt_next = watch_cnt_reg;
        if (advance && dec.count_bad && (bad_cnt_reg != emmd_pkg::COUNT_MAX)) begin
            bad_cnt_next = bad_cnt_reg + 32'd1;
        end
        if (advance && dec.watch_hit && (watch_cnt_reg != emmd_pkg::COUNT_MAX)) begin
            watch_cnt_next = watch_cnt_reg + 32'd1;
        end
        if (cfg_wr && (cfg_idx == emmd_pkg::REG_WATCH_ADDR)) begin
            watch_cnt_next = 32'b0;
        end
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            emmd_pkg::REG_ADDRESS_MASK: prdata = cfg_reg.address_mask;
            emmd_pkg::REG_MODULE_BASE:  prdata = cfg_reg.module_window_base;
            emmd_pkg::REG_MODULE_SIZE:  prdata = cfg_reg.module_window_size;
            emmd_pkg::REG_WATCH_ADDR:   prdata = cfg_reg.watched_address;
            default:                    prdata = 32'b0;
        endcase
    end

    // Control state, counters and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            bad_cnt_reg                <= 32'b0;
            watch_cnt_reg              <= 32'b0;
            cfg_reg.address_mask       <= emmd_pkg::ADDRESS_MASK_RESET;
            cfg_reg.module_window_base <= 32'b0;
            cfg_reg.module_window_size <= 32'b0;
            cfg_reg.watched_address    <= 32'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            bad_cnt_reg   <= bad_cnt_next;
            watch_cnt_reg <= watch_cnt_next;
            if (cfg_wr) begin
                case (cfg_idx)
                    emmd_pkg::REG_ADDRESS_MASK: cfg_reg.address_mask       <= pwdata;
                    emmd_pkg::REG_MODULE_BASE:  cfg_reg.module_window_base <= pwdata;
                    emmd_pkg::REG_MODULE_SIZE:  cfg_reg.module_window_size <= pwdata;
                    emmd_pkg::REG_WATCH_ADDR:   cfg_reg.watched_address    <= pwdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset; their valid flags guard them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= s_data;
        end
        if (advance) begin
            out_rsp_reg.mapped           <= dec.mapped;
            out_rsp_reg.region           <= dec.region;
            out_rsp_reg.region_offset    <= dec.region_offset;
            out_rsp_reg.store_enable     <= dec.store_enable;
            out_rsp_reg.watch_hit        <= dec.watch_hit;
            out_rsp_reg.bad_access_total <= bad_cnt_next;
            out_rsp_reg.watch_hit_total  <= watch_cnt_next;
        end
    end

endmodule

// File: rtl/emmd_checker.sv
`include "assert_macros.svh"

module emmd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input emmd_pkg::emmd_rsp_t m_data
);

    logic unmapped_clean;
    logic watch_counted;

    assign unmapped_clean = (m_data.region == emmd_pkg::REGION_NONE) &&
                            (m_data.region_offset == 32'b0) &&
                            !m_data.store_enable && !m_data.watch_hit;
    assign watch_counted  = m_data.mapped && m_data.store_enable &&
                            (m_data.watch_hit_total != 32'b0);

    // A stalled result stays offered.
    `ASSERT_NEXT(a_hold_result, aclk, aresetn, m_valid && !m_ready, m_valid)

    // Reset leaves the result channel empty.
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid)

    // An unmapped result carries no region, no offset and no side effects.
    `ASSERT_IMPLIES(a_unmapped_clean, aclk, aresetn, m_valid && !m_data.mapped, unmapped_clean)

    // A mapped result names a real region.
    `ASSERT_IMPLIES(a_mapped_region, aclk, aresetn, m_valid && m_data.mapped, m_data.region != emmd_pkg::REGION_NONE)

    // A watch hit is a mapped store and has been counted.
    `ASSERT_IMPLIES(a_watch_counted, aclk, aresetn, m_valid && m_data.watch_hit, watch_counted)

endmodule

bind emulated_memory_map_decoder_core emmd_checker u_emmd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: test/emulated_memory_map_decoder_core_tb.sv
`timescale 1ns / 1ps

module emulated_memory_map_decoder_core_tb;
    import emmd_pkg::*;

    localparam int PHASES          = 12;
    localparam int DIRECTED_PHASE  = 1;
    localparam int STEADY_PHASE    = 4;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int IDLE_PERCENT    = 35;
    // Far beyond any legal stall: results follow their requests through the input and result registers,
    // and random back-pressure never holds the result channel for long.
    localparam int STALL_LIMIT     = 2000;
    localparam int PRINT_LIMIT     = 40;

    // Every input starts at a known value before the first clock edge.
    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    emmd_req_t s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    emmd_rsp_t m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // While set, neither side of the stream inserts idle cycles.
    bit steady = 1'b0;
    int unsigned quiet_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    emulated_memory_map_decoder_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Scoreboard: keeps its own copy of the registers and both counters, decodes
    // each accepted request the way the block should, and holds the decodes
    // until the matching results come back in order.
    class decode_scoreboard;
        emmd_cfg_t   cfg;
        logic [31:0] bad_total;
        logic [31:0] watch_total;
        emmd_rsp_t   expected_decodes[$];
        int unsigned errors;
        int unsigned results;
        int unsigned requests;
        int unsigned region_count[5];
        int unsigned watch_hits;
        int unsigned bad_singles;

        function new();
            cfg.address_mask       = ADDRESS_MASK_RESET;
            cfg.module_window_base = '0;
            cfg.module_window_size = '0;
            cfg.watched_address    = '0;
            bad_total   = '0;
            watch_total = '0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ADDRESS_MASK: cfg.address_mask = value;
                REG_MODULE_BASE:  cfg.module_window_base = value;
                REG_MODULE_SIZE:  cfg.module_window_size = value;
                REG_WATCH_ADDR: begin
                    // Re-arming the watch restarts its hit count.
                    cfg.watched_address = value;
                    watch_total = '0;
                end
                default: ;
            endcase
        endfunction

        function logic [31:0] register_value(logic [1:0] idx);
            case (idx)
                REG_ADDRESS_MASK: return cfg.address_mask;
                REG_MODULE_BASE:  return cfg.module_window_base;
                REG_MODULE_SIZE:  return cfg.module_window_size;
                default:          return cfg.watched_address;
            endcase
        endfunction

        function int pending();
            return expected_decodes.size();
        endfunction

        function logic [31:0] saturate(logic [31:0] v);
            return (v == COUNT_MAX) ? v : v + 32'd1;
        endfunction

        // True when the address starts inside the window; fits tells whether
        // the whole access ends inside it too. All sums are 64 bits wide.
        function bit window_hit(longint unsigned a, longint unsigned len,
                                longint unsigned base, longint unsigned span,
                                output bit fits, output longint unsigned off);
            fits = 1'b0;
            off  = 0;
            if (span == 0 || a < base || a >= base + span)
                return 1'b0;
            off  = a - base;
            fits = (off + len) <= span;
            return 1'b1;
        endfunction

        function emmd_rsp_t decode_access(emmd_req_t req);
            emmd_rsp_t       rsp;
            longint unsigned raw;
            longint unsigned a;
            longint unsigned len;
            longint unsigned off;
            longint unsigned watch;
            bit              fits;
            bit              single;
            bit              writes;
            logic [2:0]      region;
            rsp    = '0;
            raw    = 64'(req.address);
            a      = raw & 64'(cfg.address_mask);
            len    = 64'(req.access_length);
            single = (req.action == ACT_SINGLE_READ) || (req.action == ACT_SINGLE_WRITE);
            writes = (req.action == ACT_SINGLE_WRITE) || (req.action == ACT_BLOCK_WRITE);
            // Priority order; the first window that holds the start decides,
            // even if the access then runs past its end.
            if (window_hit(a, len, 64'(cfg.module_window_base),
                           64'(cfg.module_window_size), fits, off))
                region = REGION_MODULE;
            else if (window_hit(a, len, 64'(RAM_BASE), 64'(RAM_SIZE), fits, off))
                region = REGION_RAM;
            else if (window_hit(a, len, 64'(VRAM_BASE), 64'(VRAM_SIZE), fits, off))
                region = REGION_VRAM;
            else if (window_hit(a, len, 64'(SCRATCH_BASE), 64'(SCRATCH_SIZE), fits, off))
                region = REGION_SCRATCH;
            else
                region = REGION_NONE;
            if (!fits) begin
                region = REGION_NONE;
                off    = 0;
                if (single) begin
                    bad_total = saturate(bad_total);
                    bad_singles++;
                end
            end else if (req.action == ACT_SINGLE_WRITE && cfg.watched_address != '0) begin
                // The watch compares against the raw address, not the masked one.
                watch = 64'(cfg.watched_address);
                if (raw <= watch && watch < raw + len) begin
                    rsp.watch_hit = 1'b1;
                    watch_total   = saturate(watch_total);
                    watch_hits++;
                end
            end
            rsp.mapped           = fits;
            rsp.region           = region;
            rsp.region_offset    = off[31:0];
            rsp.store_enable     = fits && writes;
            rsp.bad_access_total = bad_total;
            rsp.watch_hit_total  = watch_total;
            return rsp;
        endfunction

        function void note_request(emmd_req_t req);
            emmd_rsp_t rsp;
            rsp = decode_access(req);
            expected_decodes.push_back(rsp);
            requests++;
            region_count[rsp.region]++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= PRINT_LIMIT)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        task check_result(emmd_rsp_t got);
            emmd_rsp_t want;
            if (expected_decodes.size() == 0) begin
                report_mismatch("result arrived with no request outstanding");
                return;
            end
            want = expected_decodes.pop_front();
            results++;
            if (got.mapped !== want.mapped)
                report_mismatch($sformatf("result %0d mapped: got %b, expected %b",
                                          results, got.mapped, want.mapped));
            if (got.region !== want.region)
                report_mismatch($sformatf("result %0d region: got %0d, expected %0d",
                                          results, got.region, want.region));
            if (got.region_offset !== want.region_offset)
                report_mismatch($sformatf("result %0d region_offset: got %h, expected %h",
                                          results, got.region_offset, want.region_offset));
            if (got.store_enable !== want.store_enable)
                report_mismatch($sformatf("result %0d store_enable: got %b, expected %b",
                                          results, got.store_enable, want.store_enable));
            if (got.watch_hit !== want.watch_hit)
                report_mismatch($sformatf("result %0d watch_hit: got %b, expected %b",
                                          results, got.watch_hit, want.watch_hit));
            if (got.bad_access_total !== want.bad_access_total)
                report_mismatch($sformatf("result %0d bad_access_total: got %0d, expected %0d",
                                          results, got.bad_access_total,
                                          want.bad_access_total));
            if (got.watch_hit_total !== want.watch_hit_total)
                report_mismatch($sformatf("result %0d watch_hit_total: got %0d, expected %0d",
                                          results, got.watch_hit_total,
                                          want.watch_hit_total));
        endtask
    endclass

    decode_scoreboard sb = new();

    // Result side: random back-pressure, none during the steady phase.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // Results are sampled at the edge where they are taken.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Watchdog: a long run of cycles with no request and no result taken means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Watchdog expired after %0d cycles without progress.", STALL_LIMIT);
            $display("** emulated_memory_map_decoder_core: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one request, idling at random first, and returns on the edge at
    // which it is taken. Valid is only lowered when an idle cycle follows.
    task automatic send_request(input emmd_req_t req);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic send_access(input logic [1:0] action, input logic [31:0] address,
                               input logic [16:0] length);
        emmd_req_t req;
        req.action        = action;
        req.address       = address;
        req.access_length = length;
        send_request(req);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // APB transfers end with one cycle with psel low, so the next one can
    // start from a clean setup phase.
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic verify_register(input logic [1:0] idx);
        logic [31:0] value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (value !== sb.register_value(idx))
            sb.report_mismatch($sformatf("register %0d read back %h, expected %h",
                                         idx, value, sb.register_value(idx)));
    endtask

    task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
        apb_write(idx, value);
        verify_register(idx);
    endtask

    // Register settings per phase: a handful of fixed corners, then random ones.
    function automatic emmd_cfg_t phase_config(input int phase);
        emmd_cfg_t cfg;
        case (phase)
            DIRECTED_PHASE: begin
                // Small module window inside RAM so that priority shows.
                cfg.address_mask       = ADDRESS_MASK_RESET;
                cfg.module_window_base = RAM_BASE + 32'h1000;
                cfg.module_window_size = 32'h100;
                cfg.watched_address    = SCRATCH_BASE + 32'h10;
            end
            2: begin
                // Window reaching past 2^32; the watch sits at the very top.
                cfg.address_mask       = 32'hFFFF_FFFF;
                cfg.module_window_base = 32'hFFFF_FF00;
                cfg.module_window_size = 32'hFFFF_FFFF;
                cfg.watched_address    = 32'hFFFF_FFFF;
            end
            3: begin
                // Everything folds onto address zero.
                cfg.address_mask       = 32'h0;
                cfg.module_window_base = 32'h0;
                cfg.module_window_size = 32'h10;
                cfg.watched_address    = 32'h1;
            end
            STEADY_PHASE: begin
                cfg.address_mask       = ADDRESS_MASK_RESET;
                cfg.module_window_base = 32'h0;
                cfg.module_window_size = 32'hFFFF_FFFF;
                cfg.watched_address    = RAM_BASE + 32'h40;
            end
            5: begin
                cfg.address_mask       = 32'h0FFF_FFFF;
                cfg.module_window_base = 32'hFFFF_FFFF;
                cfg.module_window_size = 32'h0;
                cfg.watched_address    = VRAM_BASE + VRAM_SIZE - 32'h1;
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: cfg.address_mask = ADDRESS_MASK_RESET;
                    1: cfg.address_mask = 32'hFFFF_FFFF;
                    default: cfg.address_mask = $urandom;
                endcase
                case ($urandom_range(0, 3))
                    0: cfg.module_window_base = $urandom;
                    1: cfg.module_window_base = RAM_BASE + $urandom_range(0, RAM_SIZE - 1);
                    2: cfg.module_window_base = SCRATCH_BASE + $urandom_range(0, 32'h3FFF);
                    default: cfg.module_window_base = VRAM_BASE - $urandom_range(0, 32'hFFFF);
                endcase
                case ($urandom_range(0, 3))
                    0: cfg.module_window_size = 32'h0;
                    1: cfg.module_window_size = $urandom_range(1, 32'h1000);
                    2: cfg.module_window_size = $urandom;
                    default: cfg.module_window_size = 32'hFFFF_FFFF;
                endcase
                case ($urandom_range(0, 3))
                    0: cfg.watched_address = 32'h0;
                    1: cfg.watched_address = RAM_BASE + $urandom_range(0, 32'hFFFF);
                    2: cfg.watched_address = SCRATCH_BASE + $urandom_range(0, 32'h3FFF);
                    default: cfg.watched_address = $urandom;
                endcase
            end
        endcase
        return cfg;
    endfunction

    task automatic program_phase(input int phase);
        emmd_cfg_t cfg;
        cfg = phase_config(phase);
        program_register(REG_ADDRESS_MASK, cfg.address_mask);
        program_register(REG_MODULE_BASE, cfg.module_window_base);
        program_register(REG_MODULE_SIZE, cfg.module_window_size);
        program_register(REG_WATCH_ADDR, cfg.watched_address);
    endtask

    // Random access aimed mostly at window edges and at the watched address,
    // with alias bits above the mask filled in at random.
    function automatic emmd_req_t random_request();
        emmd_req_t   req;
        logic [31:0] base;
        logic [31:0] span;
        logic [31:0] off;
        logic [31:0] target;
        int unsigned kind;
        kind       = $urandom_range(0, 19);
        req.action = 2'($urandom_range(0, 3));
        if (kind >= 13 && kind <= 15 && $urandom_range(0, 3) != 0)
            req.action = ACT_SINGLE_WRITE;

        if (kind <= 3) begin
            base = RAM_BASE;
            span = RAM_SIZE;
        end else if (kind <= 6) begin
            base = VRAM_BASE;
            span = VRAM_SIZE;
        end else if (kind <= 9) begin
            base = SCRATCH_BASE;
            span = SCRATCH_SIZE;
        end else begin
            base = sb.cfg.module_window_base;
            span = sb.cfg.module_window_size;
        end

        if (kind >= 13 && kind <= 15) begin
            req.address = sb.cfg.watched_address - $urandom_range(0, 4);
        end else if (kind >= 16 || span == 0) begin
            req.address = $urandom;
        end else begin
            case ($urandom_range(0, 2))
                0: off = $urandom_range(0, 15);
                1: off = span - $urandom_range(0, 16);
                default: off = $urandom % span;
            endcase
            target      = base + off;
            req.address = (target & sb.cfg.address_mask) | ($urandom & ~sb.cfg.address_mask);
        end

        if (req.action == ACT_SINGLE_READ || req.action == ACT_SINGLE_WRITE) begin
            case ($urandom_range(0, 9))
                0: req.access_length = '0;
                1: req.access_length = 17'($urandom_range(0, 65536));
                default: req.access_length = 17'(1 << $urandom_range(0, 2));
            endcase
        end else begin
            case ($urandom_range(0, 9))
                0: req.access_length = 17'($urandom_range(0, 65536));
                1: req.access_length = 17'd65536;
                default: req.access_length = 17'($urandom_range(0, 64));
            endcase
        end
        return req;
    endfunction

    // Hand-picked accesses under the directed register setting: a module window
    // of 0x100 bytes at RAM_BASE + 0x1000, watch at SCRATCH_BASE + 0x10.
    task automatic run_directed();
        send_access(ACT_SINGLE_READ,  RAM_BASE, 17'd4);
        // The module window wins over RAM.
        send_access(ACT_SINGLE_WRITE, RAM_BASE + 32'h1000, 17'd4);
        // Runs past the module window end: unmapped, RAM is not tried.
        send_access(ACT_SINGLE_READ,  RAM_BASE + 32'h10FE, 17'd4);
        send_access(ACT_BLOCK_WRITE,  RAM_BASE + 32'h10FF, 17'd1);
        // Starts in RAM below the module window and ends inside it: still RAM.
        send_access(ACT_BLOCK_READ,   RAM_BASE + 32'h0FFF, 17'd2);
        send_access(ACT_SINGLE_READ,  RAM_BASE + RAM_SIZE - 32'd4, 17'd4);
        send_access(ACT_SINGLE_WRITE, RAM_BASE + RAM_SIZE - 32'd2, 17'd4);
        send_access(ACT_BLOCK_READ,   VRAM_BASE, 17'd65536);
        // Unmapped block: not counted as a bad access.
        send_access(ACT_BLOCK_WRITE,  VRAM_BASE + VRAM_SIZE - 32'd1, 17'd65536);
        send_access(ACT_SINGLE_READ,  VRAM_BASE - 32'd1, 17'd1);
        // Zero-length singles map, and never hit the watch.
        send_access(ACT_SINGLE_READ,  SCRATCH_BASE, 17'd0);
        send_access(ACT_SINGLE_WRITE, SCRATCH_BASE + 32'h10, 17'd0);
        // Writes covering the watched byte, and one just missing it.
        send_access(ACT_SINGLE_WRITE, SCRATCH_BASE + 32'h0E, 17'd4);
        send_access(ACT_SINGLE_WRITE, SCRATCH_BASE + 32'h0F, 17'd2);
        send_access(ACT_SINGLE_WRITE, SCRATCH_BASE + 32'h11, 17'd4);
        // An alias decodes to the same place but the raw address misses the watch.
        send_access(ACT_SINGLE_WRITE, SCRATCH_BASE + 32'h2000_0010, 17'd1);
        // Block writes are never checked against the watch.
        send_access(ACT_BLOCK_WRITE,  SCRATCH_BASE + 32'h10, 17'd4);
        send_access(ACT_SINGLE_READ,  SCRATCH_BASE + SCRATCH_SIZE - 32'd1, 17'd1);
        send_access(ACT_SINGLE_READ,  SCRATCH_BASE + SCRATCH_SIZE, 17'd1);
        send_access(ACT_SINGLE_READ,  32'h0, 17'd1);
        send_access(ACT_SINGLE_WRITE, 32'hFFFF_FFFF, 17'd65536);
        send_access(ACT_BLOCK_READ,   32'hFFFF_FFFF, 17'd1);
        send_access(ACT_SINGLE_WRITE, RAM_BASE + 32'hA000_0000, 17'd2);
        // Re-arming the watch must clear its count; then hit it once more.
        wait_idle();
        program_register(REG_WATCH_ADDR, sb.cfg.watched_address);
        send_access(ACT_SINGLE_WRITE, SCRATCH_BASE + 32'h10, 17'd1);
    endtask

    initial begin
        int phase;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values of all registers.
        verify_register(REG_ADDRESS_MASK);
        verify_register(REG_MODULE_BASE);
        verify_register(REG_MODULE_SIZE);
        verify_register(REG_WATCH_ADDR);

        // Phase zero runs on the reset setting; every later phase rewrites all
        // registers while nothing is in flight.
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                program_phase(phase);
            end
            steady = (phase == STEADY_PHASE);
            if (phase == DIRECTED_PHASE)
                run_directed();
            repeat (ITEMS_PER_PHASE)
                send_request(random_request());
        end

        wait_idle();
        repeat (4) @(posedge aclk);

        $display("Checked %0d results over %0d register settings: module %0d, RAM %0d, VRAM %0d,",
                 sb.results, PHASES, sb.region_count[REGION_MODULE],
                 sb.region_count[REGION_RAM], sb.region_count[REGION_VRAM]);
        $display("scratchpad %0d, unmapped %0d (%0d bad singles), %0d watch hits, %0d errors.",
                 sb.region_count[REGION_SCRATCH], sb.region_count[REGION_NONE],
                 sb.bad_singles, sb.watch_hits, sb.errors);
        if (sb.errors == 0)
            $display("** emulated_memory_map_decoder_core: PASSED **");
        else
            $display("** emulated_memory_map_decoder_core: FAILED **");
        $finish;
    end

endmodule
